/* rtl/core/pftc_pkg.sv */
`timescale 1ns / 1ps
// Package for the PID fan controller: widths, register indexes, reset values
// and fixed-point constants. No dependencies.
package pftc_pkg;

  // Field widths
  localparam int TEMP_W  = 16;
  localparam int DT_W    = 20;
  localparam int GAIN_W  = 16;
  localparam int LIMIT_W = 10;
  localparam int DUTY_W  = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Default for the duty resolution parameter
  localparam int DUTY_BITS_DEF = 10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KP       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUTY = 3'd6;

  // Register reset values
  localparam logic [TEMP_W-1:0]  SETPOINT_RST = 16'd7168;  // 28.0 degC
  localparam logic [LIMIT_W-1:0] OUT_HIGH_RST = 10'd1023;
  localparam logic [LIMIT_W-1:0] MIN_DUTY_RST = 10'd200;

  // Timing constants in microseconds, and the filter divisor
  localparam logic [DT_W-1:0] US_PER_S      = 20'd1000000;
  localparam logic [DT_W-1:0] DT_FLOOR_US   = 20'd10;
  localparam logic [DT_W-1:0] DT_DEFAULT_US = 20'd50000;
  localparam logic [DT_W-1:0] FILT_DIV      = 20'd10;

  // Arithmetic unit sizes
  localparam int MUL_STEPS = 20;   // multiplier bits, one per cycle
  localparam int MCAND_W   = 48;
  localparam int ACC_W     = 64;
  localparam int DIV_STEPS = 56;   // quotient bits, one per cycle
  localparam int FILT_W    = 25;   // filtered value, deg C * 2^16
  localparam int ERR_W     = 26;
  localparam int ISUM_W    = 48;

endpackage

/* rtl/core/pftc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for sample requests and result requests.
// Depends on pftc_pkg for field widths.
interface pftc_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [pftc_pkg::TEMP_W-1:0] temp_sample;
  logic [pftc_pkg::DT_W-1:0]          elapsed_us;

  modport source (output valid, temp_sample, elapsed_us, input ready);
  modport sink   (input valid, temp_sample, elapsed_us, output ready);
endinterface

interface pftc_out_if;
  logic                               valid;
  logic                               ready;
  logic [pftc_pkg::DUTY_W-1:0]        duty;
  logic signed [pftc_pkg::TEMP_W-1:0] filtered_temp_out;
  logic                               output_clamped;

  modport source (output valid, duty, filtered_temp_out, output_clamped, input ready);
  modport sink   (input valid, duty, filtered_temp_out, output_clamped, output ready);
endinterface

/* rtl/core/pid_temperature_fan_controller_top.sv */
`timescale 1ns / 1ps
// PID fan controller top level: sequencer, bit-serial multiplier and divider.
// Depends on pftc_pkg and the channel interfaces in pftc_if.sv.
//
//  channel  dir  handshake        payload
//  in_ch    in   valid/ready      temp_sample, elapsed_us
//  out_ch   out  valid/ready      duty, filtered_temp_out, output_clamped
//  cfg_*    in   cfg_wr_en only   cfg_index, cfg_wdata
//
// The first request after reset only primes the filter. Each later request
// runs up to 6 multiplies and 4 divides on one shared shift-add unit and
// one restoring divider (5 multiplies and 2 divides with the integral
// frozen and ki zero). Reset (rst_n, synchronous) restores the registers
// and clears the sequencer state, filter, integral and unit counters.
// A finished result waits in the output register; the next request is
// taken meanwhile, and the sequencer stalls only to load a new result.
module pid_temperature_fan_controller_top #(
  parameter int DUTY_BITS = pftc_pkg::DUTY_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pftc_in_if.sink                           in_ch,
  pftc_out_if.source                        out_ch,
  input  logic                              cfg_wr_en,
  input  logic [pftc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pftc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = pftc_pkg::ACC_W;
  localparam int FW = pftc_pkg::FILT_W;
  localparam int EW = pftc_pkg::ERR_W;
  localparam int IW = pftc_pkg::ISUM_W;
  localparam int MW = pftc_pkg::MCAND_W;
  localparam int DW = pftc_pkg::DT_W;
  localparam int NQ = pftc_pkg::DIV_STEPS;
  localparam logic [16:0] DUTY_MAX = 17'((64'd1 << DUTY_BITS) - 64'd1);

  // Sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_FILT  = 4'd1;
  localparam logic [3:0] ST_ERR   = 4'd2;
  localparam logic [3:0] ST_DMUL  = 4'd3;
  localparam logic [3:0] ST_DDIV  = 4'd4;
  localparam logic [3:0] ST_DTERM = 4'd5;
  localparam logic [3:0] ST_PTERM = 4'd6;
  localparam logic [3:0] ST_ITERM = 4'd7;
  localparam logic [3:0] ST_PRE   = 4'd8;
  localparam logic [3:0] ST_IMUL  = 4'd9;
  localparam logic [3:0] ST_IDIV  = 4'd10;
  localparam logic [3:0] ST_LIM   = 4'd11;
  localparam logic [3:0] ST_LDIV  = 4'd12;
  localparam logic [3:0] ST_I2GO  = 4'd13;
  localparam logic [3:0] ST_I2MUL = 4'd14;
  localparam logic [3:0] ST_SUM   = 4'd15;

  // Configuration registers
  logic [15:0]        kp_r, ki_r, kd_r;
  logic signed [15:0] setpoint_r;
  logic [9:0]         out_low_r, out_high_r, min_duty_r;

  // Controller state
  logic [3:0]               state_r;
  logic                     primed_r;
  logic signed [FW-1:0]     filt_r, prev_r;
  logic signed [EW-1:0]     err_r;
  logic signed [IW-1:0]     isum_r;
  logic [DW-1:0]            dt_r;
  logic signed [AW-1:0]     pterm_r, iterm_r, dterm_r;

  // Output register
  logic                     out_valid_r;
  logic [9:0]               duty_r;
  logic signed [15:0]       ftemp_r;
  logic                     clamped_r;

  // Bit-serial multiplier: multiplier bits MSB first into a signed accumulator
  logic [DW-1:0]            mul_a_r;
  logic signed [MW-1:0]     mul_b_r;
  logic signed [AW-1:0]     mul_acc_r;
  logic [4:0]               mul_cnt_r;

  // Restoring divider on magnitudes, one quotient bit a cycle
  logic [DW-1:0]            div_d_r;
  logic [DW-1:0]            div_rem_r;
  logic [NQ-1:0]            div_quo_r;
  logic                     div_neg_r;
  logic [5:0]               div_cnt_r;

  // Unit requests from the sequencer
  logic                     mul_start;
  logic [DW-1:0]            mul_a_nxt;
  logic signed [MW-1:0]     mul_b_nxt;
  logic                     div_start;
  logic signed [AW-1:0]     div_n_nxt;
  logic [DW-1:0]            div_d_nxt;
  logic                     div_rnd_nxt;

  logic                     mul_done, div_done;
  logic signed [AW-1:0]     div_res;
  logic signed [AW-1:0]     mul_rnd;
  logic [AW-1:0]            div_mag;
  logic [DW:0]              div_trial;
  logic                     div_ge;

  // Per-state arithmetic
  logic signed [AW-1:0]     pre_sum, hi_val, lo_val, min_val, outv, outv_c;
  logic                     pre_ok, clamp_hi, clamp_lo;
  logic signed [IW+1:0]     isum_add;
  logic signed [IW-1:0]     isum_sat, isum_lim;
  logic signed [IW:0]       lim_pos, lim_neg;
  logic [9:0]               duty_int, duty_nxt;
  logic signed [FW:0]       ftemp_rnd;
  logic signed [FW+4:0]     filt_num;
  logic                     in_acc, out_acc;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  assign mul_done = (mul_cnt_r == 5'd0);
  assign div_done = (div_cnt_r == 6'd0);

  // Signed divider result
  assign div_res = div_neg_r ? -$signed({{(AW-NQ){1'b0}}, div_quo_r})
                             :  $signed({{(AW-NQ){1'b0}}, div_quo_r});

  // Product rounded to nearest over 256, ties away from zero
  assign mul_rnd = (mul_acc_r + (mul_acc_r[AW-1] ? 64'sd127 : 64'sd128)) >>> 8;

  // Output limits in 2^-24 duty counts
  assign hi_val  = $signed({30'd0, out_high_r, 24'd0});
  assign lo_val  = $signed({30'd0, out_low_r, 24'd0});
  assign min_val = $signed({30'd0, min_duty_r, 24'd0});

  // Trial output and the anti-windup gate
  assign pre_sum = pterm_r + iterm_r + dterm_r;
  assign pre_ok  = (pre_sum < hi_val || err_r < 0) && (pre_sum > lo_val || err_r > 0);

  // Integral update saturated to 48 bits
  assign isum_add = 50'(isum_r) + 50'(div_res);
  always_comb begin
    if (isum_add > 50'sh0_7FFF_FFFF_FFFF) isum_sat = {1'b0, {(IW-1){1'b1}}};
    else if (isum_add < -50'sh0_8000_0000_0000) isum_sat = {1'b1, {(IW-1){1'b0}}};
    else isum_sat = isum_add[IW-1:0];
  end

  // Integral clamp to +-lim; lim is the positive divider quotient
  assign lim_pos = $signed({1'b0, div_quo_r[IW-1:0]});
  assign lim_neg = -lim_pos;
  always_comb begin
    isum_lim = isum_r;
    if (49'(isum_r) > lim_pos) isum_lim = lim_pos[IW-1:0];
    if (49'(isum_r) < lim_neg) isum_lim = lim_neg[IW-1:0];
  end

  // Final output, saturation and duty mapping
  assign outv = pterm_r + iterm_r + dterm_r;
  always_comb begin
    outv_c   = outv;
    clamp_hi = outv > hi_val;
    if (clamp_hi) outv_c = hi_val;
    clamp_lo = outv_c < lo_val;
    if (clamp_lo) outv_c = lo_val;
    duty_int = outv_c[33:24];
    duty_nxt = 10'd0;
    if (outv_c >= min_val) begin
      duty_nxt = duty_int;
      if ({7'd0, duty_int} > DUTY_MAX) duty_nxt = DUTY_MAX[9:0];
    end
  end

  // Filtered temperature back to Q8.8, rounded
  assign ftemp_rnd = (26'(filt_r) + (filt_r[FW-1] ? 26'sd127 : 26'sd128)) >>> 8;

  // Filter numerator: incoming sample + 9 * filtered
  assign filt_num = (30'(in_ch.temp_sample) <<< 8) + (30'(filt_r) <<< 3) + 30'(filt_r);

  // Unit request decode
  always_comb begin
    mul_start   = 1'b0;
    mul_a_nxt   = '0;
    mul_b_nxt   = '0;
    div_start   = 1'b0;
    div_n_nxt   = '0;
    div_d_nxt   = '0;
    div_rnd_nxt = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        div_n_nxt = 64'(filt_num);
        div_d_nxt = pftc_pkg::FILT_DIV;
        div_start = in_acc && primed_r;
      end
      ST_ERR: begin
        mul_a_nxt = pftc_pkg::US_PER_S;
        mul_b_nxt = 48'(prev_r) - 48'(filt_r);
        mul_start = 1'b1;
      end
      ST_DMUL: begin
        div_n_nxt = mul_acc_r;
        div_d_nxt = dt_r;
        div_start = mul_done;
      end
      ST_DDIV: begin
        mul_a_nxt = {4'd0, kd_r};
        mul_b_nxt = div_res[MW-1:0];
        mul_start = div_done;
      end
      ST_DTERM: begin
        mul_a_nxt = {4'd0, kp_r};
        mul_b_nxt = 48'(err_r);
        mul_start = mul_done;
      end
      ST_PTERM: begin
        mul_a_nxt = {4'd0, ki_r};
        mul_b_nxt = isum_r;
        mul_start = mul_done;
      end
      ST_PRE: begin
        mul_a_nxt = dt_r;
        mul_b_nxt = 48'(err_r);
        mul_start = pre_ok;
      end
      ST_IMUL: begin
        div_n_nxt = mul_acc_r <<< 8;
        div_d_nxt = pftc_pkg::US_PER_S;
        div_start = mul_done;
      end
      ST_LIM: begin
        div_n_nxt   = $signed({22'd0, out_high_r, 32'd0});
        div_d_nxt   = {4'd0, ki_r};
        div_rnd_nxt = 1'b0;
        div_start   = (ki_r != 16'd0);
      end
      ST_I2GO: begin
        mul_a_nxt = {4'd0, ki_r};
        mul_b_nxt = isum_r;
        mul_start = 1'b1;
      end
      default: ;
    endcase
  end

  // Divider load: magnitude plus half the divisor when rounding
  assign div_mag = (div_n_nxt[AW-1] ? ~div_n_nxt : div_n_nxt)
                 + 64'(div_rnd_nxt ? (div_d_nxt >> 1) : 20'd0)
                 + 64'(div_n_nxt[AW-1]);
  assign div_trial = {div_rem_r, div_quo_r[NQ-1]};
  assign div_ge    = (div_trial >= {1'b0, div_d_r});

  // Arithmetic units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      if (mul_start) begin
        mul_a_r   <= mul_a_nxt;
        mul_b_r   <= mul_b_nxt;
        mul_acc_r <= '0;
        mul_cnt_r <= 5'(pftc_pkg::MUL_STEPS);
      end else if (!mul_done) begin
        mul_acc_r <= (mul_acc_r <<< 1) + (mul_a_r[DW-1] ? 64'(mul_b_r) : 64'sd0);
        mul_a_r   <= mul_a_r << 1;
        mul_cnt_r <= mul_cnt_r - 5'd1;
      end
      if (div_start) begin
        div_d_r   <= div_d_nxt;
        div_rem_r <= '0;
        div_quo_r <= div_mag[NQ-1:0];
        div_neg_r <= div_n_nxt[AW-1];
        div_cnt_r <= 6'(NQ);
      end else if (!div_done) begin
        div_rem_r <= div_ge ? DW'(div_trial - {1'b0, div_d_r}) : div_trial[DW-1:0];
        div_quo_r <= {div_quo_r[NQ-2:0], div_ge};
        div_cnt_r <= div_cnt_r - 6'd1;
      end
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r       <= '0;
      ki_r       <= '0;
      kd_r       <= '0;
      setpoint_r <= pftc_pkg::SETPOINT_RST;
      out_low_r  <= '0;
      out_high_r <= pftc_pkg::OUT_HIGH_RST;
      min_duty_r <= pftc_pkg::MIN_DUTY_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pftc_pkg::REG_KP:       kp_r       <= cfg_wdata;
        pftc_pkg::REG_KI:       ki_r       <= cfg_wdata;
        pftc_pkg::REG_KD:       kd_r       <= cfg_wdata;
        pftc_pkg::REG_SETPOINT: setpoint_r <= cfg_wdata;
        pftc_pkg::REG_OUT_LOW:  out_low_r  <= cfg_wdata[9:0];
        pftc_pkg::REG_OUT_HIGH: out_high_r <= cfg_wdata[9:0];
        pftc_pkg::REG_MIN_DUTY: min_duty_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      filt_r      <= '0;
      prev_r      <= '0;
      isum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the final state reloads the output register itself
      if (out_acc && state_r != ST_SUM) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            dt_r     <= (in_ch.elapsed_us <= pftc_pkg::DT_FLOOR_US)
                        ? pftc_pkg::DT_DEFAULT_US : in_ch.elapsed_us;
            if (!primed_r) begin
              filt_r   <= 25'(in_ch.temp_sample) <<< 8;
              prev_r   <= 25'(in_ch.temp_sample) <<< 8;
              primed_r <= 1'b1;
            end else begin
              state_r <= ST_FILT;
            end
          end
        end
        ST_FILT: if (div_done) begin
          filt_r  <= div_res[FW-1:0];
          state_r <= ST_ERR;
        end
        ST_ERR: begin
          err_r   <= 26'(filt_r) - (26'(setpoint_r) <<< 8);
          prev_r  <= filt_r;
          state_r <= ST_DMUL;
        end
        ST_DMUL:  if (mul_done) state_r <= ST_DDIV;
        ST_DDIV:  if (div_done) state_r <= ST_DTERM;
        ST_DTERM: if (mul_done) begin
          dterm_r <= mul_acc_r;
          state_r <= ST_PTERM;
        end
        ST_PTERM: if (mul_done) begin
          pterm_r <= mul_acc_r;
          state_r <= ST_ITERM;
        end
        ST_ITERM: if (mul_done) begin
          iterm_r <= mul_rnd;
          state_r <= ST_PRE;
        end
        ST_PRE:   state_r <= pre_ok ? ST_IMUL : ST_LIM;
        ST_IMUL:  if (mul_done) state_r <= ST_IDIV;
        ST_IDIV:  if (div_done) begin
          isum_r  <= isum_sat;
          state_r <= ST_LIM;
        end
        ST_LIM:   state_r <= (ki_r != 16'd0) ? ST_LDIV : ST_I2GO;
        ST_LDIV:  if (div_done) begin
          isum_r  <= isum_lim;
          state_r <= ST_I2GO;
        end
        ST_I2GO:  state_r <= ST_I2MUL;
        ST_I2MUL: if (mul_done) begin
          iterm_r <= mul_rnd;
          state_r <= ST_SUM;
        end
        ST_SUM: begin
          // load the result once the output register is free
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            duty_r      <= duty_nxt;
            ftemp_r     <= ftemp_rnd[15:0];
            clamped_r   <= clamp_hi || clamp_lo;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.duty              = duty_r;
  assign out_ch.filtered_temp_out = ftemp_r;
  assign out_ch.output_clamped    = clamped_r;

  // Shared units never run together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_cnt_r != 5'd0 && div_cnt_r != 6'd0))
    else $error("multiplier and divider busy at once");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (div_cnt_r != 6'd0) |-> (div_rem_r < div_d_r))
    else $error("divider remainder out of range");

  // A result is loaded only from the final state
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_SUM))
    else $error("result loaded outside final state");

  // Once primed, stays primed
  a_primed: assert property (@(posedge clk) disable iff (!rst_n)
    primed_r |=> primed_r)
    else $error("primed flag dropped");

endmodule

/* tb/pid_temperature_fan_controller_top_test.sv */
`timescale 1ns / 1ps
// Testbench for the PID fan controller: drives temperature sample requests
// through phases of register settings and checks each result request.
// Depends on pftc_pkg, pftc_if.sv and pid_temperature_fan_controller_top.
module pid_temperature_fan_controller_top_test;

  localparam longint OUT_ONE = 64'sd16777216;
  localparam longint INT48_MAX = 64'sd140737488355327;
  localparam longint INT48_MIN = -64'sd140737488355328;
  localparam int CYCLE_LIMIT = 12000000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct packed {
    logic signed [pftc_pkg::TEMP_W-1:0] temp;
    logic [pftc_pkg::DT_W-1:0]          dt;
  } sample_t;

  typedef struct packed {
    logic [pftc_pkg::DUTY_W-1:0]        duty;
    logic signed [pftc_pkg::TEMP_W-1:0] filt;
    logic                               clamped;
  } fan_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [pftc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pftc_pkg::CFG_DATA_W-1:0] cfg_wdata;

  pftc_in_if  in_ch();
  pftc_out_if out_ch();

  pid_temperature_fan_controller_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Predictor copy of the registers and loop state
  logic [pftc_pkg::GAIN_W-1:0]  kp, ki, kd;
  logic signed [pftc_pkg::TEMP_W-1:0] setpoint;
  logic [pftc_pkg::LIMIT_W-1:0] lim_low, lim_high, duty_floor;
  longint filt_val, prev_val, isum;
  bit primed;

  sample_t     pending_samples[$];
  fan_result_t expected_results[$];
  int errors;
  int cycles;
  bit in_fired;

  // Round to nearest, ties away from zero; d > 0
  function automatic longint round_div(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // One control step of the PID loop
  task automatic predict_fan_step(sample_t s);
    longint smp, f, err, deriv, pterm, iterm, dterm, pre, outv, hi, lo, lim, dt, duty, ftmp;
    fan_result_t r;
    smp = longint'(s.temp) * 256;
    dt = longint'(s.dt);
    if (!primed) begin
      filt_val = smp;
      prev_val = smp;
      primed = 1;
      return;
    end
    f = round_div(smp + 9 * filt_val, 10);
    filt_val = f;
    if (dt <= 10) dt = 50000;
    err = f - longint'(setpoint) * 256;
    deriv = round_div(-(f - prev_val) * 1000000, dt);
    prev_val = f;
    hi = longint'(lim_high) * OUT_ONE;
    lo = longint'(lim_low) * OUT_ONE;
    pterm = longint'(kp) * err;
    dterm = longint'(kd) * deriv;
    iterm = round_div(longint'(ki) * isum, 256);
    pre = pterm + iterm + dterm;
    // anti-windup: only integrate when not pushing further into a limit
    if ((pre < hi || err < 0) && (pre > lo || err > 0)) begin
      isum += round_div(err * dt * 256, 1000000);
      if (isum > INT48_MAX) isum = INT48_MAX;
      if (isum < INT48_MIN) isum = INT48_MIN;
    end
    if (ki > 0) begin
      lim = (longint'(lim_high) <<< 32) / longint'(ki);
      if (isum > lim) isum = lim;
      if (isum < -lim) isum = -lim;
    end
    iterm = round_div(longint'(ki) * isum, 256);
    outv = pterm + iterm + dterm;
    r.clamped = 0;
    if (outv > hi) begin
      outv = hi;
      r.clamped = 1;
    end
    if (outv < lo) begin
      outv = lo;
      r.clamped = 1;
    end
    duty = 0;
    if (outv >= longint'(duty_floor) * OUT_ONE) duty = outv / OUT_ONE;
    if (duty > (64'sd1 <<< pftc_pkg::DUTY_BITS_DEF) - 1)
      duty = (64'sd1 <<< pftc_pkg::DUTY_BITS_DEF) - 1;
    if (duty > 1023) duty = 1023;
    ftmp = round_div(f, 256);
    if (ftmp > 32767) ftmp = 32767;
    if (ftmp < -32768) ftmp = -32768;
    r.duty = duty[pftc_pkg::DUTY_W-1:0];
    r.filt = ftmp[pftc_pkg::TEMP_W-1:0];
    expected_results.push_back(r);
  endtask

  // Clock and run limit
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Monitor: check results, then record accepted requests
  always @(posedge clk) begin
    fan_result_t got, exp_r;
    in_fired = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.duty = out_ch.duty;
      got.filt = out_ch.filtered_temp_out;
      got.clamped = out_ch.output_clamped;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result duty=%0d filt=%0d clamped=%0b",
                                   got.duty, got.filt, got.clamped);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: exp duty=%0d filt=%0d clamped=%0b got duty=%0d filt=%0d clamped=%0b",
                     exp_r.duty, exp_r.filt, exp_r.clamped, got.duty, got.filt, got.clamped);
        end
      end
    end
    if (in_fired)
      predict_fan_step('{temp: in_ch.temp_sample, dt: in_ch.elapsed_us});
  end

  // Driver: bursts of requests separated by random gaps
  int burst_left, gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
    end else if (!in_ch.valid || in_fired) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 0;
      end else if (pending_samples.size() > 0) begin
        sample_t s;
        s = pending_samples.pop_front();
        in_ch.valid <= 1;
        in_ch.temp_sample <= s.temp;
        in_ch.elapsed_us <= s.dt;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 7);
          gap_left = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
        end
      end else begin
        in_ch.valid <= 0;
      end
    end
  end

  // Receiver: stall modes switched at random
  int ready_mode, mode_left, stall_left;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(50, 3000);
    end else mode_left--;
    case (ready_mode)
      0: out_ch.ready <= 1;
      1: out_ch.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_ch.ready <= 0;
        end else begin
          out_ch.ready <= 1;
          if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 400);
        end
      end
    endcase
  end

  task automatic write_reg(logic [pftc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pftc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      pftc_pkg::REG_KP:       kp = val;
      pftc_pkg::REG_KI:       ki = val;
      pftc_pkg::REG_KD:       kd = val;
      pftc_pkg::REG_SETPOINT: setpoint = val;
      pftc_pkg::REG_OUT_LOW:  lim_low = val[pftc_pkg::LIMIT_W-1:0];
      pftc_pkg::REG_OUT_HIGH: lim_high = val[pftc_pkg::LIMIT_W-1:0];
      pftc_pkg::REG_MIN_DUTY: duty_floor = val[pftc_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic logic [pftc_pkg::GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom_range(64, 1024));
    endcase
  endfunction

  // Write all registers for one phase; phases 1 and 2 take the extremes
  task automatic set_phase_regs(int ph);
    if (ph == 1) begin
      write_reg(pftc_pkg::REG_KP, 16'hFFFF);
      write_reg(pftc_pkg::REG_KI, 16'hFFFF);
      write_reg(pftc_pkg::REG_KD, 16'hFFFF);
      write_reg(pftc_pkg::REG_SETPOINT, 16'h8000);
      write_reg(pftc_pkg::REG_OUT_LOW, 16'd1023);   // crossed limits
      write_reg(pftc_pkg::REG_OUT_HIGH, 16'd0);
      write_reg(pftc_pkg::REG_MIN_DUTY, 16'd1023);
    end else if (ph == 2) begin
      write_reg(pftc_pkg::REG_KP, 16'd0);
      write_reg(pftc_pkg::REG_KI, 16'd0);
      write_reg(pftc_pkg::REG_KD, 16'd0);
      write_reg(pftc_pkg::REG_SETPOINT, 16'h7FFF);
      write_reg(pftc_pkg::REG_OUT_LOW, 16'd0);
      write_reg(pftc_pkg::REG_OUT_HIGH, 16'd1023);
      write_reg(pftc_pkg::REG_MIN_DUTY, 16'd0);
    end else begin
      write_reg(pftc_pkg::REG_KP, pick_gain());
      write_reg(pftc_pkg::REG_KI, pick_gain());
      write_reg(pftc_pkg::REG_KD, pick_gain());
      write_reg(pftc_pkg::REG_SETPOINT,
                16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(5120, 10240)));
      write_reg(pftc_pkg::REG_OUT_LOW,
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 300)));
      write_reg(pftc_pkg::REG_OUT_HIGH,
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(600, 1023)));
      write_reg(pftc_pkg::REG_MIN_DUTY,
                16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, 400)));
    end
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    int t;
    if ($urandom_range(0, 5) == 0) s.temp = 16'($urandom_range(0, 65535));
    else begin
      t = int'(setpoint) + $urandom_range(0, 6000) - 3000;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      s.temp = t[pftc_pkg::TEMP_W-1:0];
    end
    case ($urandom_range(0, 7))
      0: s.dt = 20'($urandom_range(0, 10));          // short interval
      1: s.dt = 20'($urandom_range(0, 1048575));
      2: s.dt = 20'($urandom_range(11, 100));
      default: s.dt = 20'($urandom_range(20000, 80000));
    endcase
    return s;
  endfunction

  // Stimulus: directed requests, then random phases
  initial begin
    errors = 0;
    cycles = 0;
    primed = 0;
    in_fired = 0;
    kp = 0; ki = 0; kd = 0;
    setpoint = pftc_pkg::SETPOINT_RST;
    lim_low = 0; lim_high = pftc_pkg::OUT_HIGH_RST; duty_floor = pftc_pkg::MIN_DUTY_RST;
    filt_val = 0; prev_val = 0; isum = 0;
    burst_left = 0; gap_left = 0;
    ready_mode = 0; mode_left = 0; stall_left = 0;
    rst_n = 0;
    cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0;
    in_ch.valid = 0; in_ch.temp_sample = '0; in_ch.elapsed_us = '0;
    out_ch.ready = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    for (int ph = 0; ph < PHASES; ph++) begin
      set_phase_regs(ph);
      if (ph == 0) begin
        // priming request, field extremes, short and long intervals
        pending_samples.push_back('{temp: 16'sd7168, dt: 20'd50000});
        pending_samples.push_back('{temp: 16'h8000, dt: 20'd0});
        pending_samples.push_back('{temp: 16'h7FFF, dt: 20'd10});
        pending_samples.push_back('{temp: 16'h7FFF, dt: 20'd11});
        pending_samples.push_back('{temp: 16'h0000, dt: 20'hFFFFF});
        pending_samples.push_back('{temp: 16'hFFFF, dt: 20'd1});
        pending_samples.push_back('{temp: 16'h5555, dt: 20'hAAAAA});
        pending_samples.push_back('{temp: 16'hAAAA, dt: 20'h55555});
        pending_samples.push_back('{temp: 16'h8000, dt: 20'd11});
        pending_samples.push_back('{temp: 16'sd7168, dt: 20'd50000});
        pending_samples.push_back('{temp: 16'sd9000, dt: 20'd50000});
        pending_samples.push_back('{temp: 16'sd5000, dt: 20'd50000});
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) pending_samples.push_back(random_sample());
      wait (pending_samples.size() == 0 && !in_ch.valid && expected_results.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end

    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
